[design/crfd_pkg.sv]
package crfd_pkg;

  localparam int unsigned RING_SLOTS = 8;
  localparam int unsigned SLOT_W     = $clog2(RING_SLOTS);

  localparam logic [15:0] RING_LIMIT = 16'd8000;
  localparam logic [13:0] LONG_OFS   = 14'd2500;
  localparam logic [11:0] LAT_OFS    = 12'd1023;
  localparam logic [14:0] RECIP5     = 15'd13108;  // ceil(2^16 / 5)

  localparam int unsigned CFG_W = 11;
  localparam logic [1:0] CFG_SECTOR_WIDTH = 2'd0;
  localparam logic [1:0] CFG_RING_NODE    = 2'd1;
  localparam logic [1:0] CFG_OBJECT_ID    = 2'd2;

  localparam logic [9:0]  SECTOR_WIDTH_RST = 10'd3;
  localparam logic [6:0]  RING_NODE_RST    = 7'h20;
  localparam logic [10:0] OBJECT_ID_RST    = 11'h60B;

  localparam logic [2:0] SECT_FWD       = 3'd0;
  localparam logic [2:0] SECT_RIGHT     = 3'd1;
  localparam logic [2:0] SECT_REAR      = 3'd4;
  localparam logic [2:0] SECT_LEFT      = 3'd7;
  localparam logic [2:0] CLS_MAX        = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RING,
    ST_SECT,
    ST_OBJ_A,
    ST_OBJ_B
  } state_e;

  typedef struct packed {
    logic       done;
    logic [2:0] first;
    logic [2:0] second;
    logic       in_width;
  } sect_status_t;

  // Lateral offset field of an object frame, offset removed.
  function automatic logic signed [11:0] lat_of(input logic [63:0] bytes);
    logic [11:0] raw;
    raw = {1'b0, bytes[18:16], bytes[31:24]};
    return $signed(raw - LAT_OFS);
  endfunction

endpackage

[design/crfd_sector.sv]
module crfd_sector (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [11:0]        lat_i,
  input  logic [9:0]                width_i,
  output crfd_pkg::sect_status_t    status_o
);

  logic        run_q, run_d;
  logic [2:0]  cls_q, cls_d;
  logic [10:0] alat_q;
  logic        neg_q;
  logic [9:0]  w_q;
  logic [12:0] mult;
  logic        pass;
  logic [2:0]  first;

  // Multiple of the width checked at each step: 1, 4, 6, 8.
  always_comb begin
    case (cls_q[1:0])
      2'd0:    mult = {3'b000, w_q};
      2'd1:    mult = {1'b0, w_q, 2'b00};
      2'd2:    mult = {1'b0, w_q, 2'b00} + {2'b00, w_q, 1'b0};
      default: mult = {w_q, 3'b000};
    endcase
    pass = (cls_q != crfd_pkg::CLS_MAX) && ({2'b00, alat_q} >= mult);
  end

  always_comb begin
    run_d = run_q;
    cls_d = cls_q;
    if (start_i) begin
      run_d = 1'b1;
      cls_d = '0;
    end else if (run_q) begin
      if (pass) begin
        cls_d = cls_q + 3'd1;
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cls_q <= '0;
    end else begin
      run_q <= run_d;
      cls_q <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      alat_q <= lat_i[11] ? 11'(-lat_i) : lat_i[10:0];
      neg_q  <= lat_i[11];
      w_q    <= (width_i == '0) ? 10'd1 : width_i;
    end
  end

  always_comb begin
    case (cls_q)
      3'd0:    first = crfd_pkg::SECT_FWD;
      3'd1:    first = neg_q ? 3'd7 : 3'd1;
      3'd2:    first = neg_q ? 3'd6 : 3'd2;
      3'd3:    first = neg_q ? 3'd5 : 3'd3;
      default: first = crfd_pkg::SECT_REAR;
    endcase
  end

  assign status_o.done     = run_q && !pass;
  assign status_o.first    = first;
  assign status_o.second   = (alat_q > {1'b0, w_q}) ?
                             (neg_q ? crfd_pkg::SECT_LEFT : crfd_pkg::SECT_RIGHT) :
                             crfd_pkg::SECT_FWD;
  assign status_o.in_width = (cls_q == 3'd0);

endmodule

[design/can_radar_frame_decoder_top.sv]
// Decodes received CAN frames from a ring radar and an object radar. Frames whose
// source node (identifier bits 6..0) matches the ring node feed a three-frame
// assembler; the third frame of a set yields eight distance items in centimetres,
// one per cycle while the output is not stalled, slot 0 first. A frame whose full
// identifier matches the object frame identifier, unless it completes a ring set,
// yields two sector-write items. The block drops tready after accepting a frame
// that yields items and keeps it low until they are in the output register. An
// object frame first takes one to five steps of the shared lateral-offset
// comparator; an ignored or intermediate frame leaves tready high.
module can_radar_frame_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // frame_id, frame_bytes, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot, distance, object_number, long_pos, lat_pos, long_speed, lat_speed,
  // motion_class, cross_section, within_width, zero pad
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast   // last
);

  localparam int unsigned SW = crfd_pkg::SLOT_W;

  logic [9:0]  sector_width_q;
  logic [6:0]  ring_node_q;
  logic [10:0] object_id_q;

  crfd_pkg::state_e state_q, state_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [1:0]  phase_q, phase_d, phase_eff;
  logic [15:0] dist_q [crfd_pkg::RING_SLOTS];
  logic [15:0] dist_d [crfd_pkg::RING_SLOTS];
  logic [63:0] frame_q;
  logic [11:0] quot_q;

  logic [28:0] in_id;
  logic [63:0] in_bytes;
  logic        accept, node_hit, obj_hit, ring_done, sect_start;

  logic        out_valid_q, out_free;
  logic        out_kind_q, out_last_q, out_within_q;
  logic [2:0]  out_slot_q;
  logic [17:0] out_dist_q;
  logic [7:0]  out_objnum_q, out_cross_q;
  logic [13:0] out_long_q;
  logic [11:0] out_lat_q;
  logic [9:0]  out_vlong_q;
  logic [8:0]  out_vlat_q;
  logic [2:0]  out_motion_q;
  logic        load_ring, load_obj;

  logic signed [13:0] lp;
  logic signed [11:0] lat;
  logic [9:0]  vl;
  logic [8:0]  vt;
  logic [12:0] lp_mag;
  logic [27:0] lp_prod;
  logic [15:0] ring_r;
  logic [17:0] ring_cm;

  crfd_pkg::sect_status_t sect;

  assign in_id    = s_axis_tdata[28:0];
  assign in_bytes = s_axis_tdata[92:29];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == crfd_pkg::ST_IDLE);

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_width_q <= crfd_pkg::SECTOR_WIDTH_RST;
      ring_node_q    <= crfd_pkg::RING_NODE_RST;
      object_id_q    <= crfd_pkg::OBJECT_ID_RST;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        crfd_pkg::CFG_SECTOR_WIDTH: sector_width_q <= cfg_data_i[9:0];
        crfd_pkg::CFG_RING_NODE:    ring_node_q    <= cfg_data_i[6:0];
        crfd_pkg::CFG_OBJECT_ID:    object_id_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring assembler
  assign node_hit  = (in_id[6:0] == ring_node_q);
  assign obj_hit   = (in_id == {18'd0, object_id_q});
  assign phase_eff = (phase_q == 2'd0 && in_bytes[7:0] == 8'd1) ? 2'd1 : phase_q;
  assign ring_done = node_hit && (phase_eff == 2'd3);

  always_comb begin
    for (int i = 0; i < crfd_pkg::RING_SLOTS; i++) begin
      dist_d[i] = dist_q[i];
    end
    phase_d = phase_q;
    if (accept && node_hit) begin
      case (phase_eff)
        2'd1: begin
          dist_d[0] = in_bytes[47:32];
          dist_d[1] = {8'd0, in_bytes[55:48]};
        end
        2'd2: begin
          dist_d[1] = {dist_q[1][15:8] + in_bytes[7:0], dist_q[1][7:0]};
          dist_d[2] = in_bytes[23:8];
          dist_d[3] = in_bytes[39:24];
          dist_d[4] = in_bytes[55:40];
        end
        2'd3: begin
          dist_d[5] = in_bytes[15:0];
          dist_d[6] = in_bytes[31:16];
          dist_d[7] = in_bytes[47:32];
        end
        default: ;
      endcase
      phase_d = (phase_eff == 2'd0 || phase_eff == 2'd3) ? 2'd0 : phase_eff + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      for (int i = 0; i < crfd_pkg::RING_SLOTS; i++) begin
        dist_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      for (int i = 0; i < crfd_pkg::RING_SLOTS; i++) begin
        dist_q[i] <= dist_d[i];
      end
    end
  end

  // Sector search
  assign sect_start = accept && !ring_done && obj_hit;

  crfd_sector u_sector (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sect_start),
    .lat_i    (crfd_pkg::lat_of(in_bytes)),
    .width_i  (sector_width_q),
    .status_o (sect)
  );

  // Object fields from the held frame
  assign lp  = $signed({1'b0, frame_q[15:8], frame_q[23:19]} - crfd_pkg::LONG_OFS);
  assign lat = crfd_pkg::lat_of(frame_q);
  assign vl  = {frame_q[39:32], frame_q[47:46]} - 10'd512;
  assign vt  = {frame_q[45:40], frame_q[55:53]} - 9'd256;
  assign lp_mag  = lp[13] ? 13'(-lp) : lp[12:0];
  assign lp_prod = 28'(lp_mag) * 28'(crfd_pkg::RECIP5);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= in_bytes;
    end
    if (state_q == crfd_pkg::ST_SECT) begin
      quot_q <= lp_prod[27:16];
    end
  end

  // Ring distance in centimetres
  assign ring_r  = dist_q[slot_q];
  assign ring_cm = (ring_r >= crfd_pkg::RING_LIMIT) ? 18'd0 :
                   ({2'b00, ring_r} << 3) + ({2'b00, ring_r} << 1);

  // Sequencer
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    load_ring = 1'b0;
    load_obj  = 1'b0;
    case (state_q)
      crfd_pkg::ST_IDLE: begin
        slot_d = '0;
        if (accept) begin
          if (ring_done) begin
            state_d = crfd_pkg::ST_RING;
          end else if (obj_hit) begin
            state_d = crfd_pkg::ST_SECT;
          end
        end
      end
      crfd_pkg::ST_RING: begin
        if (out_free) begin
          load_ring = 1'b1;
          slot_d    = slot_q + SW'(1);
          if (slot_q == SW'(crfd_pkg::RING_SLOTS - 1)) begin
            state_d = crfd_pkg::ST_IDLE;
          end
        end
      end
      crfd_pkg::ST_SECT: begin
        if (sect.done) begin
          state_d = crfd_pkg::ST_OBJ_A;
        end
      end
      crfd_pkg::ST_OBJ_A: begin
        if (out_free) begin
          load_obj = 1'b1;
          state_d  = crfd_pkg::ST_OBJ_B;
        end
      end
      crfd_pkg::ST_OBJ_B: begin
        if (out_free) begin
          load_obj = 1'b1;
          state_d  = crfd_pkg::ST_IDLE;
        end
      end
      default: state_d = crfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crfd_pkg::ST_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (load_ring || load_obj) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_ring) begin
      out_kind_q   <= 1'b0;
      out_slot_q   <= 3'(slot_q);
      out_dist_q   <= ring_cm;
      out_objnum_q <= '0;
      out_long_q   <= '0;
      out_lat_q    <= '0;
      out_vlong_q  <= '0;
      out_vlat_q   <= '0;
      out_motion_q <= '0;
      out_cross_q  <= '0;
      out_within_q <= 1'b0;
      out_last_q   <= (slot_q == SW'(crfd_pkg::RING_SLOTS - 1));
    end else if (load_obj) begin
      out_kind_q   <= 1'b1;
      out_slot_q   <= (state_q == crfd_pkg::ST_OBJ_A) ? sect.first : sect.second;
      out_dist_q   <= lp[13] ? 18'(-{6'd0, quot_q}) : {6'd0, quot_q};
      out_objnum_q <= frame_q[7:0];
      out_long_q   <= lp;
      out_lat_q    <= lat;
      out_vlong_q  <= vl;
      out_vlat_q   <= vt;
      out_motion_q <= frame_q[50:48];
      out_cross_q  <= {~frame_q[63], frame_q[62:56]};
      out_within_q <= sect.in_width;
      out_last_q   <= (state_q == crfd_pkg::ST_OBJ_B);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_within_q, out_cross_q, out_motion_q, out_vlat_q,
                          out_vlong_q, out_lat_q, out_long_q, out_objnum_q, out_dist_q,
                          out_slot_q};

`ifndef SYNTHESIS
  a_ring_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata[2:0] == 3'd7)
    else $error("ring item marked last on a slot other than the final one");

  a_ring_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crfd_pkg::ST_RING |-> phase_q == 2'd0)
    else $error("ring items emitted while the assembler is mid-set");

  a_within_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata[85] |-> m_axis_tdata[2:0] == 3'd0)
    else $error("object inside sector width written to a side sector");

  a_ring_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[85:21] == '0)
    else $error("ring item carries object fields");
`endif

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE       = 12;
  localparam int END_SLACK    = 30;
  localparam int PRINT_CAP    = 100;

  localparam logic KIND_RING   = 1'b0;
  localparam logic KIND_OBJECT = 1'b1;

  // sectors not named in the package
  localparam logic [2:0] SECT_RIGHT_WIDE = 3'd2;
  localparam logic [2:0] SECT_RIGHT_SIDE = 3'd3;
  localparam logic [2:0] SECT_LEFT_SIDE  = 3'd5;
  localparam logic [2:0] SECT_LEFT_WIDE  = 3'd6;

  typedef struct packed {
    logic              kind;
    logic [2:0]        slot;
    logic signed [17:0] distance;
    logic [7:0]        object_number;
    logic signed [13:0] long_pos;
    logic signed [11:0] lat_pos;
    logic signed [9:0] long_speed;
    logic signed [8:0] lat_speed;
    logic [2:0]        motion_class;
    logic signed [7:0] cross_section;
    logic              within_width;
    logic              last;
  } radar_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [1:0]  cfg_index_i;
  logic [10:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // mirror of the decoder's registers and ring assembler
  logic [9:0]  cfg_sector_width = crfd_pkg::SECTOR_WIDTH_RST;
  logic [6:0]  cfg_ring_node    = crfd_pkg::RING_NODE_RST;
  logic [10:0] cfg_object_id    = crfd_pkg::OBJECT_ID_RST;
  int          ring_step        = 0;
  logic [15:0] ring_dist [crfd_pkg::RING_SLOTS];

  radar_item_t pending_items [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          quiet       = 1'b0;

  can_radar_frame_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("can_radar_frame_decoder_top verification failed");
      $finish;
    end
  end

  // Mostly back-to-back, sometimes short pauses, rarely long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Work out the items one received frame causes and queue them.
  function automatic void decode_frame(input logic [28:0] id, input logic [63:0] bytes);
    logic [7:0]  b [8];
    radar_item_t it;
    bit          ring_done;
    int          k, r, w, lp, lat, alat, vl, vt, s;
    logic [2:0]  first, second;
    for (k = 0; k < 8; k++) b[k] = bytes[8*k +: 8];
    ring_done = 1'b0;
    if (id[6:0] == cfg_ring_node) begin
      if (ring_step == 0 && b[0] == 8'd1) ring_step = 1;
      case (ring_step)
        1: begin
          ring_dist[0] = {b[5], b[4]};
          ring_dist[1] = {8'h00, b[6]};
        end
        2: begin
          ring_dist[1] = ring_dist[1] + {b[0], 8'h00};
          ring_dist[2] = {b[2], b[1]};
          ring_dist[3] = {b[4], b[3]};
          ring_dist[4] = {b[6], b[5]};
        end
        3: begin
          ring_dist[5] = {b[1], b[0]};
          ring_dist[6] = {b[3], b[2]};
          ring_dist[7] = {b[5], b[4]};
        end
        default: ;
      endcase
      if (ring_step == 3) begin
        ring_step = 0;
        ring_done = 1'b1;
      end else if (ring_step != 0) begin
        ring_step++;
      end
    end

    if (ring_done) begin
      for (k = 0; k < crfd_pkg::RING_SLOTS; k++) begin
        it = '0;
        it.kind = KIND_RING;
        it.slot = k[2:0];
        r = ring_dist[k];
        if (r >= crfd_pkg::RING_LIMIT) r = 0;
        else r = r * 10;
        it.distance = r[17:0];
        it.last = (k == crfd_pkg::RING_SLOTS - 1);
        pending_items.push_back(it);
      end
      return;
    end

    if (id == {18'd0, cfg_object_id}) begin
      w = (cfg_sector_width == 0) ? 1 : cfg_sector_width;
      lp = {b[1], b[2][7:3]};
      lp = lp - 2500;
      lat = {b[2][2:0], b[3]};
      lat = lat - 1023;
      vl = {b[4], b[5][7:6]};
      vl = vl - 512;
      vt = {b[5][5:0], b[6][7:5]};
      vt = vt - 256;
      alat = (lat < 0) ? -lat : lat;
      s = lat / w;
      if (s == 0) first = crfd_pkg::SECT_FWD;
      else if (s >= 1 && s <= 3) first = crfd_pkg::SECT_RIGHT;
      else if (s >= 4 && s <= 5) first = SECT_RIGHT_WIDE;
      else if (s >= 6 && s <= 7) first = SECT_RIGHT_SIDE;
      else if (s >= -3 && s <= -1) first = crfd_pkg::SECT_LEFT;
      else if (s >= -5 && s <= -4) first = SECT_LEFT_WIDE;
      else if (s >= -7 && s <= -6) first = SECT_LEFT_SIDE;
      else first = crfd_pkg::SECT_REAR;
      if (lat > w) second = crfd_pkg::SECT_RIGHT;
      else if (lat < -w) second = crfd_pkg::SECT_LEFT;
      else second = crfd_pkg::SECT_FWD;

      it = '0;
      it.kind = KIND_OBJECT;
      it.slot = first;
      r = lp / 5;
      it.distance = r[17:0];
      it.object_number = b[0];
      it.long_pos = lp[13:0];
      it.lat_pos = lat[11:0];
      it.long_speed = vl[9:0];
      it.lat_speed = vt[8:0];
      it.motion_class = b[6][2:0];
      r = b[7];
      r = r - 128;
      it.cross_section = r[7:0];
      it.within_width = (alat < w);
      it.last = 1'b0;
      pending_items.push_back(it);
      it.slot = second;
      it.last = 1'b1;
      pending_items.push_back(it);
    end
  endfunction

  task automatic check_result;
    radar_item_t got, want;
    got.kind          = m_axis_tuser;
    got.slot          = m_axis_tdata[2:0];
    got.distance      = m_axis_tdata[20:3];
    got.object_number = m_axis_tdata[28:21];
    got.long_pos      = m_axis_tdata[42:29];
    got.lat_pos       = m_axis_tdata[54:43];
    got.long_speed    = m_axis_tdata[64:55];
    got.lat_speed     = m_axis_tdata[73:65];
    got.motion_class  = m_axis_tdata[76:74];
    got.cross_section = m_axis_tdata[84:77];
    got.within_width  = m_axis_tdata[85];
    got.last          = m_axis_tlast;
    if (pending_items.size() == 0) begin
      report_mismatch("output item with nothing pending");
    end else begin
      want = pending_items.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("slot", got.slot, want.slot);
      check_field("distance", got.distance, want.distance);
      check_field("object_number", got.object_number, want.object_number);
      check_field("long_pos", got.long_pos, want.long_pos);
      check_field("lat_pos", got.lat_pos, want.lat_pos);
      check_field("long_speed", got.long_speed, want.long_speed);
      check_field("lat_speed", got.lat_speed, want.lat_speed);
      check_field("motion_class", got.motion_class, want.motion_class);
      check_field("cross_section", got.cross_section, want.cross_section);
      check_field("within_width", got.within_width, want.within_width);
      check_field("last", got.last, want.last);
    end
  endtask

  // Output side: check each accepted item, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= 1'b1;
      hold_cycles = gap_len();
    end
  end

  task automatic send_frame(input logic [28:0] id, input logic [63:0] bytes);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, bytes, id};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_frame(id, bytes);
  endtask

  // Drop valid and hold until every queued item has come out.
  task automatic wait_idle;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_items.size() != 0) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [9:0] sw, input logic [6:0] node,
                             input logic [10:0] oid);
    wait_idle();
    repeat (SETTLE) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= crfd_pkg::CFG_SECTOR_WIDTH;
    cfg_data_i  <= {1'b0, sw};
    @(posedge clk_i);
    cfg_sector_width = sw;
    cfg_index_i <= crfd_pkg::CFG_RING_NODE;
    cfg_data_i  <= {4'b0000, node};
    @(posedge clk_i);
    cfg_ring_node = node;
    cfg_index_i <= crfd_pkg::CFG_OBJECT_ID;
    cfg_data_i  <= oid;
    @(posedge clk_i);
    cfg_object_id = oid;
    cfg_wr_en_i <= 1'b0;
  endtask

  function automatic logic [28:0] noise_id();
    logic [28:0] id;
    id = 29'($urandom);
    return id;
  endfunction

  function automatic logic [28:0] ring_id();
    logic [28:0] id;
    id = 29'($urandom);
    id[6:0] = cfg_ring_node;
    return id;
  endfunction

  // Random object payload with the lateral offset forced to lat.
  function automatic logic [63:0] object_with_lat(input int lat);
    logic [63:0] bytes;
    logic [10:0] raw;
    bytes = {$urandom, $urandom};
    raw = 11'(lat + 1023);
    bytes[18:16] = raw[10:8];
    bytes[31:24] = raw[7:0];
    return bytes;
  endfunction

  // Three frames carrying eight distances; optionally slip noise in between.
  task automatic send_ring_set(input logic [15:0] dists [crfd_pkg::RING_SLOTS],
                               input bit interleave);
    logic [63:0] f [3];
    int k;
    f[0] = {$urandom, $urandom};
    f[0][7:0]   = 8'd1;
    f[0][47:32] = dists[0];
    f[0][55:48] = dists[1][7:0];
    f[1] = {$urandom, $urandom};
    f[1][7:0]   = dists[1][15:8];
    f[1][23:8]  = dists[2];
    f[1][39:24] = dists[3];
    f[1][55:40] = dists[4];
    f[2] = {$urandom, $urandom};
    f[2][15:0]  = dists[5];
    f[2][31:16] = dists[6];
    f[2][47:32] = dists[7];
    for (k = 0; k < 3; k++) begin
      send_frame(ring_id(), f[k]);
      if (interleave && k < 2) send_frame(noise_id(), {$urandom, $urandom});
    end
  endtask

  task automatic test_reset_defaults;
    logic [15:0] dists [crfd_pkg::RING_SLOTS];
    logic [28:0] id;
    dists = '{16'd0, 16'd7999, 16'd8000, 16'hFFFF, 16'd1, 16'h8000, 16'd7998, 16'd8001};
    // ring node frame that does not arm the assembler
    id = 29'h1FFFFF80 | 29'(cfg_ring_node);
    send_frame(id, 64'hFFFF_FFFF_FFFF_FF00);
    send_ring_set(dists, 1'b0);
    send_frame({18'd0, cfg_object_id}, 64'h0);
    send_frame({18'd0, cfg_object_id}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame({18'd0, cfg_object_id}, object_with_lat(0));
    send_frame({18'd0, cfg_object_id}, object_with_lat(3));
    send_frame({18'd0, cfg_object_id}, object_with_lat(-3));
    send_frame({18'd0, cfg_object_id}, object_with_lat(4));
    send_frame({18'd0, cfg_object_id}, object_with_lat(-4));
    send_frame({18'd0, cfg_object_id}, object_with_lat(2));
    send_frame(29'h1FFFFFFF, 64'h0123_4567_89AB_CDEF);
  endtask

  // Identifier matches both decoders: the completing frame yields ring items only.
  task automatic test_both_kinds;
    logic [63:0] bytes;
    reconfigure(10'd3, crfd_pkg::OBJECT_ID_RST[6:0], crfd_pkg::OBJECT_ID_RST);
    bytes = {$urandom, $urandom};
    bytes[7:0] = 8'd1;
    send_frame({18'd0, cfg_object_id}, bytes);
    send_frame({18'd0, cfg_object_id}, {$urandom, $urandom});
    send_frame({18'd0, cfg_object_id}, {$urandom, $urandom});
  endtask

  task automatic test_width_extremes;
    reconfigure(10'd0, 7'd127, 11'd2047);
    send_frame({18'd0, cfg_object_id}, object_with_lat(1));
    send_frame({18'd0, cfg_object_id}, object_with_lat(-1));
    send_frame({18'd0, cfg_object_id}, object_with_lat(0));
    reconfigure(10'd1023, 7'd0, 11'd0);
    send_frame({18'd0, cfg_object_id}, object_with_lat(1024));
    send_frame({18'd0, cfg_object_id}, object_with_lat(-1023));
    send_frame({18'd0, cfg_object_id}, object_with_lat(1023));
  endtask

  task automatic test_random_traffic(input int n_items);
    logic [15:0] dists [crfd_pkg::RING_SLOTS];
    logic [63:0] bytes;
    int sent, pick, k, w, lat;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) wait_idle();
      if (pick < 45) begin
        for (k = 0; k < crfd_pkg::RING_SLOTS; k++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: dists[k] = 16'($urandom_range(0, 7999));
            5:             dists[k] = 16'($urandom_range(7998, 8001));
            default:       dists[k] = 16'($urandom);
          endcase
        end
        send_ring_set(dists, $urandom_range(0, 4) == 0);
        sent += 3;
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          bytes = {$urandom, $urandom};
        end else begin
          w = (cfg_sector_width == 0) ? 1 : cfg_sector_width;
          lat = w * ($urandom_range(0, 18) - 9) + $urandom_range(0, 2) - 1;
          if (lat > 1024) lat = 1024;
          if (lat < -1023) lat = -1023;
          bytes = object_with_lat(lat);
        end
        send_frame({18'd0, cfg_object_id}, bytes);
        sent++;
      end else if (pick < 90) begin
        // stray ring node frame, may arm or advance the assembler
        send_frame(ring_id(), {$urandom, $urandom});
        sent++;
      end else begin
        send_frame(noise_id(), {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  task automatic test_random_phases;
    logic [9:0]  sw;
    logic [6:0]  node;
    logic [10:0] oid;
    int p;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin sw = 10'd1;    node = 7'd0;   oid = 11'd2047; end
        1: begin sw = 10'd1023; node = 7'd127; oid = 11'd0;    end
        default: begin
          sw   = 10'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) :
                                                   $urandom_range(1, 1023));
          node = 7'($urandom);
          oid  = 11'($urandom);
          if (p == 3) oid[6:0] = node;
        end
      endcase
      reconfigure(sw, node, oid);
      quiet = (p == 2);
      test_random_traffic(52);
      quiet = 1'b0;
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < crfd_pkg::RING_SLOTS; k++) ring_dist[k] = '0;
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_index_i   = crfd_pkg::CFG_SECTOR_WIDTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_both_kinds();
    test_width_extremes();
    test_random_phases();

    wait_idle();
    repeat (END_SLACK) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("can_radar_frame_decoder_top verification clean");
    end else begin
      $display("can_radar_frame_decoder_top verification failed");
    end
    $finish;
  end

endmodule
